// ===== hdl/idsd_pkg.sv =====
package idsd_pkg;

	localparam int unsigned LETTER_COUNT = 19;
	localparam int unsigned RADIX_DIGITS = 9;

	localparam logic [7:0] CHAR_SEP = 8'h2D;     // '-'
	localparam logic [7:0] CHAR_DIGIT_LO = 8'h31; // '1'
	localparam logic [7:0] CHAR_DIGIT_HI = 8'h39; // '9'

	localparam logic [4:0] NO_LETTER = 5'd31;

	// listed letters, the index is the letter part of a base-171 digit
	localparam logic [7:0] LETTER_SET [LETTER_COUNT] = '{
		8'h41, 8'h42, 8'h43, 8'h45, 8'h48, 8'h49, 8'h4B, 8'h4C, 8'h4E, 8'h4F,
		8'h50, 8'h52, 8'h53, 8'h54, 8'h55, 8'h57, 8'h58, 8'h59, 8'h5A
	};

	typedef enum logic [1:0] {
		KIND_SEP,
		KIND_LETTER,
		KIND_DIGIT,
		KIND_OTHER
	} kind_t;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_DIGIT,
		PH_TAIL
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_MALFORMED,
		ST_OVERFLOW
	} status_t;

	// one classified character
	typedef struct packed {
		kind_t      kind;
		logic [4:0] letter;
		logic [3:0] digit;
		logic       last;
	} item_t;

	function automatic logic [4:0] find_letter(input logic [7:0] c);
		logic [4:0] idx;
		idx = NO_LETTER;
		for (int i = LETTER_COUNT - 1; i >= 0; i--) begin
			if (LETTER_SET[i] == c) begin
				idx = 5'(i);
			end
		end
		return idx;
	endfunction

endpackage

// ===== hdl/idsd_front.sv =====
module idsd_front (
	input  logic [7:0]     char_in,
	input  logic           last_char,
	output idsd_pkg::item_t item
);

	logic [4:0] letter_idx;
	logic       is_digit;

	assign letter_idx = idsd_pkg::find_letter(char_in);
	assign is_digit   = (char_in >= idsd_pkg::CHAR_DIGIT_LO) &&
	                    (char_in <= idsd_pkg::CHAR_DIGIT_HI);

	always_comb begin
		item.last   = last_char;
		item.letter = letter_idx;
		item.digit  = 4'(char_in - idsd_pkg::CHAR_DIGIT_LO);
		priority if (char_in == idsd_pkg::CHAR_SEP) begin
			item.kind = idsd_pkg::KIND_SEP;
		end else if (letter_idx != idsd_pkg::NO_LETTER) begin
			item.kind = idsd_pkg::KIND_LETTER;
		end else if (is_digit) begin
			item.kind = idsd_pkg::KIND_DIGIT;
		end else begin
			item.kind = idsd_pkg::KIND_OTHER;
		end
	end

endmodule

// ===== hdl/idsd_fifo.sv =====
module idsd_fifo #(
	parameter int unsigned DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_valid,
	output logic            wr_ready,
	input  idsd_pkg::item_t wr_item,
	output logic            rd_valid,
	input  logic            rd_en,
	output idsd_pkg::item_t rd_item
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	idsd_pkg::item_t mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            push;
	logic            pop;

	assign wr_ready = (count_q != CW'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_en && rd_valid;
	assign rd_item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== hdl/idsd_back.sv =====
module idsd_back #(
	parameter int unsigned MAX_POSITIONS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_pop,
	input  idsd_pkg::item_t in_item,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [127:0]    out_value,
	output logic [4:0]      out_positions,
	output logic [1:0]      out_status
);

	idsd_pkg::phase_t  phase_q, phase_n;
	idsd_pkg::status_t err_q, err_n, fin_err;
	logic [127:0]      acc_q, acc_n, acc_mul;
	logic [4:0]        li_q, li_n;
	logic [4:0]        cnt_q, cnt_n;
	logic [7:0]        digit_val;

	logic              out_valid_q;
	logic [127:0]      value_q;
	logic [4:0]        positions_q;
	idsd_pkg::status_t status_q;

	// a last character needs a free result slot, others never wait
	assign in_pop = in_valid && (!in_item.last || !out_valid_q || out_ready);

	// letter * 9 + digit, then acc * 171 + that as shifts and adds
	assign digit_val = {li_q, 3'b000} + {3'b000, li_q} + {4'b0000, in_item.digit};
	assign acc_mul   = (acc_q << 7) + (acc_q << 5) + (acc_q << 3) + (acc_q << 1)
	                 + acc_q + {120'd0, digit_val};

	always_comb begin
		phase_n = phase_q;
		err_n   = err_q;
		acc_n   = acc_q;
		li_n    = li_q;
		cnt_n   = cnt_q;
		if (err_q == idsd_pkg::ST_OK) begin
			unique case (phase_q)
				idsd_pkg::PH_IDLE: begin
					if (in_item.kind == idsd_pkg::KIND_LETTER) begin
						li_n    = in_item.letter;
						phase_n = idsd_pkg::PH_DIGIT;
					end else if (in_item.kind != idsd_pkg::KIND_SEP) begin
						err_n = idsd_pkg::ST_MALFORMED;
					end
				end
				idsd_pkg::PH_DIGIT: begin
					if (in_item.kind != idsd_pkg::KIND_DIGIT) begin
						err_n = idsd_pkg::ST_MALFORMED;
					end else if (cnt_q >= 5'(MAX_POSITIONS)) begin
						err_n = idsd_pkg::ST_OVERFLOW;
					end else begin
						acc_n   = acc_mul;
						cnt_n   = cnt_q + 1'b1;
						phase_n = idsd_pkg::PH_TAIL;
					end
				end
				idsd_pkg::PH_TAIL: begin
					if (in_item.kind == idsd_pkg::KIND_SEP) begin
						phase_n = idsd_pkg::PH_IDLE;
					end
				end
				default: begin
					phase_n = idsd_pkg::PH_IDLE;
				end
			endcase
		end
		// string ending right after a letter
		if (err_n == idsd_pkg::ST_OK && phase_n == idsd_pkg::PH_DIGIT) begin
			fin_err = idsd_pkg::ST_MALFORMED;
		end else begin
			fin_err = err_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= idsd_pkg::PH_IDLE;
			err_q   <= idsd_pkg::ST_OK;
			acc_q   <= '0;
			li_q    <= '0;
			cnt_q   <= '0;
		end else if (in_pop) begin
			if (in_item.last) begin
				phase_q <= idsd_pkg::PH_IDLE;
				err_q   <= idsd_pkg::ST_OK;
				acc_q   <= '0;
				li_q    <= '0;
				cnt_q   <= '0;
			end else begin
				phase_q <= phase_n;
				err_q   <= err_n;
				acc_q   <= acc_n;
				li_q    <= li_n;
				cnt_q   <= cnt_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_pop && in_item.last) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_pop && in_item.last) begin
			value_q     <= (fin_err == idsd_pkg::ST_OK) ? acc_n : '0;
			positions_q <= cnt_n;
			status_q    <= fin_err;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_value     = value_q;
	assign out_positions = positions_q;
	assign out_status    = status_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 5'(MAX_POSITIONS))
		else $error("position count beyond limit");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q != idsd_pkg::ST_OK |-> value_q == '0)
		else $error("error result with nonzero value");

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		in_pop && in_item.last |=> phase_q == idsd_pkg::PH_IDLE && cnt_q == '0
			&& err_q == idsd_pkg::ST_OK && acc_q == '0)
		else $error("state not cleared after end of string");

	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		err_q != idsd_pkg::ST_OK && !(in_pop && in_item.last) |=> $stable(err_q))
		else $error("error code changed inside a string");

endmodule

// ===== hdl/id_string_to_integer_decoder.sv =====
// channel  dir  handshake                 payload
// s_axis   in   s_tvalid / s_tready       s_tdata char_in, s_tlast last_char
// m_axis   out  m_tvalid / m_tready       m_tdata value_high, value_low, positions;
//                                         m_tuser status
//
// one character per cycle while the queue has room; a character is written into the queue before it reaches the decode
// stage, and the result is registered when the decode stage takes the last character
// s_tready drops only while the character queue is full
// the decode stage waits only on a last character while a result is untaken
// arst_n clears the queue, the decode state and the result valid flag
module id_string_to_integer_decoder #(
	parameter int unsigned MAX_POSITIONS = 16,
	parameter int unsigned QUEUE_DEPTH   = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,  // [7:0] char_in
	input  logic         s_tlast,  // last_char
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [135:0] m_tdata,  // [63:0] value_high, [127:64] value_low,
	                               // [132:128] positions, rest zero
	output logic [1:0]   m_tuser   // [1:0] status
);

	idsd_pkg::item_t front_item;   // classified character from the front
	idsd_pkg::item_t queue_item;   // head of the queue
	logic            queue_valid;
	logic            back_pop;
	logic [127:0]    value;
	logic [4:0]      positions;

	// front: per-character lookup of separator, listed letter or digit
	idsd_front u_front (
		.char_in   (s_tdata),
		.last_char (s_tlast),
		.item      (front_item)
	);

	// short queue so a stalled result does not block the input side at once
	idsd_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (s_tvalid),
		.wr_ready (s_tready),
		.wr_item  (front_item),
		.rd_valid (queue_valid),
		.rd_en    (back_pop),
		.rd_item  (queue_item)
	);

	// back: token state machine and base-171 accumulation
	idsd_back #(
		.MAX_POSITIONS (MAX_POSITIONS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (queue_valid),
		.in_pop        (back_pop),
		.in_item       (queue_item),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.out_value     (value),
		.out_positions (positions),
		.out_status    (m_tuser)
	);

	// high half first in the low bits
	assign m_tdata = {3'b000, positions, value[63:0], value[127:64]};

endmodule

// ===== verif/id_string_to_integer_decoder_tb.sv =====
`timescale 1ns / 100ps

module id_string_to_integer_decoder_tb;

	import idsd_pkg::*;

	localparam int unsigned MAX_TOKENS   = 16;
	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam int unsigned DRAIN_CYCLES = 24;   // margin to catch a stray result
	localparam int unsigned RANDOM_CHARS = 450;
	localparam int unsigned MIN_STRINGS  = 40;
	localparam logic [127:0] ID_RADIX    = 128'(LETTER_COUNT * RADIX_DIGITS);

	// one decoded id as it leaves the block
	typedef struct packed {
		logic [63:0] hi;
		logic [63:0] lo;
		logic [4:0]  pos;
		status_t     st;
	} id_result_t;

	// one row of the directed table; typed rows carry a hand-written result
	typedef struct packed {
		logic [7:0] ch;
		logic       is_last;
		logic       typed;
		id_result_t want;
	} stim_row_t;

	localparam id_result_t NO_RESULT = '0;

	localparam int unsigned N_ROWS = 27;
	localparam stim_row_t DIRECTED [N_ROWS] = '{
		// lowest letter, lowest digit: value 0, one token
		'{8'h41, 1'b0, 1'b0, NO_RESULT},
		'{8'h31, 1'b1, 1'b1, '{64'd0, 64'd0, 5'd1, ST_OK}},
		// highest letter, highest digit: value 170
		'{8'h5A, 1'b0, 1'b0, NO_RESULT},
		'{8'h39, 1'b1, 1'b1, '{64'd0, 64'd170, 5'd1, ST_OK}},
		// separators only
		'{8'h2D, 1'b1, 1'b1, '{64'd0, 64'd0, 5'd0, ST_OK}},
		// letter not in the set
		'{8'h44, 1'b1, 1'b1, '{64'd0, 64'd0, 5'd0, ST_MALFORMED}},
		// digit zero is not a valid digit
		'{8'h41, 1'b0, 1'b0, NO_RESULT},
		'{8'h30, 1'b1, 1'b1, '{64'd0, 64'd0, 5'd0, ST_MALFORMED}},
		// string ends right after a letter
		'{8'h42, 1'b1, 1'b1, '{64'd0, 64'd0, 5'd0, ST_MALFORMED}},
		// token ends right after a letter
		'{8'h41, 1'b0, 1'b0, NO_RESULT},
		'{8'h2D, 1'b1, 1'b1, '{64'd0, 64'd0, 5'd0, ST_MALFORMED}},
		// byte zero as a whole string
		'{8'h00, 1'b1, 1'b1, '{64'd0, 64'd0, 5'd0, ST_MALFORMED}},
		// leading and doubled separators, tail with 0xff, two tokens
		'{8'h2D, 1'b0, 1'b0, NO_RESULT},
		'{8'h43, 1'b0, 1'b0, NO_RESULT},
		'{8'h33, 1'b0, 1'b0, NO_RESULT},
		'{8'hFF, 1'b0, 1'b0, NO_RESULT},
		'{8'h2D, 1'b0, 1'b0, NO_RESULT},
		'{8'h2D, 1'b0, 1'b0, NO_RESULT},
		'{8'h45, 1'b0, 1'b0, NO_RESULT},
		'{8'h35, 1'b1, 1'b0, NO_RESULT},
		// first error sticks, a later good token changes nothing
		'{8'h44, 1'b0, 1'b0, NO_RESULT},
		'{8'h41, 1'b0, 1'b0, NO_RESULT},
		'{8'h31, 1'b1, 1'b1, '{64'd0, 64'd0, 5'd0, ST_MALFORMED}},
		// error after one good token keeps its count
		'{8'h4B, 1'b0, 1'b0, NO_RESULT},
		'{8'h32, 1'b0, 1'b0, NO_RESULT},
		'{8'h2D, 1'b0, 1'b0, NO_RESULT},
		'{8'h30, 1'b1, 1'b1, '{64'd0, 64'd0, 5'd1, ST_MALFORMED}}
	};

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [7:0]   s_tdata;   // [7:0] char_in
	logic         s_tlast;   // last_char
	logic         m_tvalid;
	logic         m_tready;
	logic [135:0] m_tdata;   // [63:0] value_high, [127:64] value_low, [132:128] positions
	logic [1:0]   m_tuser;   // [1:0] status

	// decoder state mirrored by the testbench
	logic [127:0] dec_acc;
	phase_t       dec_phase;
	logic [4:0]   dec_letter;
	logic [4:0]   dec_count;
	status_t      dec_status;

	id_result_t   pending_ids[$];   // decoded ids still owed by the block
	logic [7:0]   id_chars[$];      // the string being built for the next transactions
	id_result_t   got_id;
	id_result_t   want_id;
	int unsigned  mismatches = 0;
	int unsigned  cycles = 0;
	int unsigned  sent_chars;
	int unsigned  sent_strings;
	logic         no_idle;          // burst mode: neither side inserts gaps

	id_string_to_integer_decoder #(
		.MAX_POSITIONS(MAX_TOKENS)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	task automatic report_mismatch(input string what);
		$display("[%0t] mismatch: %s", $realtime, what);
		mismatches++;
	endtask

	function automatic int idle_cycles();
		if (no_idle) begin
			return 0;
		end
		return $urandom_range(0, 6);
	endfunction

	// index of c in the listed letters, -1 when it is not listed
	function automatic int letter_slot(input logic [7:0] c);
		int slot;
		slot = -1;
		for (int i = 0; i < LETTER_COUNT; i++) begin
			if (slot < 0 && LETTER_SET[i] == c) begin
				slot = i;
			end
		end
		return slot;
	endfunction

	task automatic clear_decoder();
		dec_acc    = '0;
		dec_phase  = PH_IDLE;
		dec_letter = '0;
		dec_count  = '0;
		dec_status = ST_OK;
	endtask

	// advance the mirrored decoder by one character; a last character yields an id
	task automatic decode_char(input logic [7:0] c, input logic is_last,
			output logic has_result, output id_result_t res);
		int slot;
		int digit_val;
		has_result = 1'b0;
		res        = '0;
		if (dec_status == ST_OK) begin
			case (dec_phase)
				PH_IDLE: begin
					if (c != CHAR_SEP) begin
						slot = letter_slot(c);
						if (slot < 0) begin
							dec_status = ST_MALFORMED;
						end else begin
							dec_letter = 5'(slot);
							dec_phase  = PH_DIGIT;
						end
					end
				end
				PH_DIGIT: begin
					if (c >= CHAR_DIGIT_LO && c <= CHAR_DIGIT_HI) begin
						if (dec_count >= MAX_TOKENS) begin
							dec_status = ST_OVERFLOW;
						end else begin
							// base-171 digit, most significant token first
							digit_val = int'(dec_letter) * RADIX_DIGITS
								+ int'(c) - int'(CHAR_DIGIT_LO);
							dec_acc   = dec_acc * ID_RADIX + 128'(digit_val);
							dec_count = dec_count + 5'd1;
							dec_phase = PH_TAIL;
						end
					end else begin
						dec_status = ST_MALFORMED;
					end
				end
				default: begin
					// tail of a token: only a separator matters
					if (c == CHAR_SEP) begin
						dec_phase = PH_IDLE;
					end
				end
			endcase
		end
		if (is_last) begin
			if (dec_status == ST_OK && dec_phase == PH_DIGIT) begin
				dec_status = ST_MALFORMED;
			end
			has_result = 1'b1;
			res.pos    = dec_count;
			res.st     = dec_status;
			if (dec_status == ST_OK) begin
				res.hi = dec_acc[127:64];
				res.lo = dec_acc[63:0];
			end
			clear_decoder();
		end
	endtask

	// one character transaction; entered and left at a falling edge
	task automatic send_char(input logic [7:0] c, input logic is_last,
			input logic typed, input id_result_t typed_res);
		int         gap;
		logic       has_result;
		id_result_t res;
		gap = idle_cycles();
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= c;
		s_tlast  <= is_last;
		do begin
			@(posedge clk);
		end while (!s_tready);
		decode_char(c, is_last, has_result, res);
		if (has_result) begin
			pending_ids.push_back(typed ? typed_res : res);
		end
		sent_chars++;
		@(negedge clk);
	endtask

	task automatic send_id_chars();
		no_idle = ($urandom_range(0, 4) == 0);
		for (int i = 0; i < id_chars.size(); i++) begin
			send_char(id_chars[i], i == id_chars.size() - 1, 1'b0, NO_RESULT);
		end
		sent_strings++;
	endtask

	// hold the sender until the block has delivered everything owed
	task automatic wait_for_results();
		s_tvalid <= 1'b0;
		while (pending_ids.size() != 0) begin
			@(negedge clk);
		end
	endtask

	// a character biased toward the ones the decoder cares about
	function automatic logic [7:0] mixed_char();
		case ($urandom_range(0, 5))
			0: return CHAR_SEP;
			1: return LETTER_SET[$urandom_range(0, LETTER_COUNT - 1)];
			2: return 8'h30 + 8'($urandom_range(0, 9));
			3: return $urandom_range(0, 1) ? 8'h00 : 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// well-formed id: tokens of letter, digit and an optional ignored tail
	task automatic build_wellformed(input int ntok);
		logic [7:0] c;
		id_chars.delete();
		if ($urandom_range(0, 3) == 0) begin
			id_chars.push_back(CHAR_SEP);
		end
		for (int t = 0; t < ntok; t++) begin
			if (t > 0) begin
				repeat (($urandom_range(0, 4) == 0) ? $urandom_range(2, 3) : 1) begin
					id_chars.push_back(CHAR_SEP);
				end
			end
			id_chars.push_back(LETTER_SET[$urandom_range(0, LETTER_COUNT - 1)]);
			id_chars.push_back(CHAR_DIGIT_LO + 8'($urandom_range(0, 8)));
			if ($urandom_range(0, 2) == 0) begin
				repeat ($urandom_range(1, 3)) begin
					do begin
						c = 8'($urandom_range(0, 255));
					end while (c == CHAR_SEP);
					id_chars.push_back(c);
				end
			end
		end
		if ($urandom_range(0, 3) == 0 || id_chars.size() == 0) begin
			id_chars.push_back(CHAR_SEP);
		end
	endtask

	function automatic int token_count();
		int r;
		r = $urandom_range(0, 99);
		if (r < 5) begin
			return 0;
		end else if (r < 80) begin
			return $urandom_range(1, 5);
		end else if (r < 92) begin
			return $urandom_range(6, MAX_TOKENS);
		end
		return $urandom_range(MAX_TOKENS + 1, MAX_TOKENS + 2);
	endfunction

	// receiver: random stall before each result transaction
	initial begin
		int gap;
		m_tready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			gap = idle_cycles();
			if (gap != 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_tready <= 1'b1;
			do begin
				@(posedge clk);
			end while (!m_tvalid);
			@(negedge clk);
		end
	end

	// result checker: each accepted transaction against the oldest pending id
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got_id.hi  = m_tdata[63:0];
			got_id.lo  = m_tdata[127:64];
			got_id.pos = m_tdata[132:128];
			got_id.st  = status_t'(m_tuser);
			if (pending_ids.size() == 0) begin
				report_mismatch($sformatf("unexpected result hi=%h lo=%h pos=%0d st=%0d",
					got_id.hi, got_id.lo, got_id.pos, got_id.st));
			end else begin
				want_id = pending_ids.pop_front();
				if (got_id.hi !== want_id.hi) begin
					report_mismatch($sformatf("value_high %h, want %h", got_id.hi, want_id.hi));
				end
				if (got_id.lo !== want_id.lo) begin
					report_mismatch($sformatf("value_low %h, want %h", got_id.lo, want_id.lo));
				end
				if (got_id.pos !== want_id.pos) begin
					report_mismatch($sformatf("positions %0d, want %0d",
						got_id.pos, want_id.pos));
				end
				if (got_id.st !== want_id.st) begin
					report_mismatch($sformatf("status %0d, want %0d", got_id.st, want_id.st));
				end
				if (m_tdata[135:133] !== 3'b000) begin
					report_mismatch($sformatf("tdata padding %b", m_tdata[135:133]));
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		int r;
		int victim;
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		s_tlast      = 1'b0;
		no_idle      = 1'b0;
		sent_chars   = 0;
		sent_strings = 0;
		clear_decoder();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed table
		for (int i = 0; i < N_ROWS; i++) begin
			send_char(DIRECTED[i].ch, DIRECTED[i].is_last, DIRECTED[i].typed,
				DIRECTED[i].want);
		end
		wait_for_results();

		// full count, then one token past it
		build_wellformed(MAX_TOKENS);
		send_id_chars();
		build_wellformed(MAX_TOKENS + 1);
		send_id_chars();

		// random ids: mostly well-formed, some corrupted, some noise
		while (sent_chars < RANDOM_CHARS || sent_strings < MIN_STRINGS) begin
			r = $urandom_range(0, 99);
			if (r < 65) begin
				build_wellformed(token_count());
			end else if (r < 85) begin
				build_wellformed($urandom_range(1, 6));
				victim = $urandom_range(0, id_chars.size() - 1);
				if ($urandom_range(0, 3) == 0) begin
					// cut the string right after a character
					while (id_chars.size() > victim + 1) begin
						void'(id_chars.pop_back());
					end
				end else begin
					id_chars[victim] = mixed_char();
				end
			end else begin
				id_chars.delete();
				repeat ($urandom_range(1, 10)) begin
					id_chars.push_back(mixed_char());
				end
			end
			send_id_chars();
			if (sent_strings == 20) begin
				wait_for_results();
			end
		end
		s_tvalid <= 1'b0;

		while (pending_ids.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
